// ===== hw/rtl/fsa_pkg.sv =====
package fsa_pkg;

   localparam int INT_BITS_DEF = 32;
   localparam int POINTER_BITS_DEF = 64;

   localparam int OP_W = 2;
   localparam int CHAR_W = 8;
   localparam int ARG_W = 64;
   localparam int COUNT_W = 31;

   localparam int QUEUE_DEPTH = 4;
   localparam int DEC_DIGITS = 10;
   localparam int BCD_W = 4 * DEC_DIGITS;
   localparam int CNT_W = 6;
   localparam int NULL_LEN = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_LC_C = 8'h63;
   localparam logic [CHAR_W-1:0] CH_LC_S = 8'h73;
   localparam logic [CHAR_W-1:0] CH_LC_D = 8'h64;
   localparam logic [CHAR_W-1:0] CH_LC_I = 8'h69;
   localparam logic [CHAR_W-1:0] CH_LC_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LC_P = 8'h70;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

   localparam logic [127:0] HEX_TEXT = "0123456789abcdef";
   localparam logic [47:0] NULL_TEXT = "(null)";

   typedef enum logic [OP_W-1:0] {
      OP_FORMAT = 2'd0,
      OP_STRING = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_CHAR,
      CMD_NULL,
      CMD_DEC,
      CMD_HEX,
      CMD_PTR,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic [CHAR_W-1:0] ch;
      logic [ARG_W-1:0] arg;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NULL,
      ST_SIGN,
      ST_DABBLE,
      ST_DEC,
      ST_PFX,
      ST_HEX
   } state_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      c = HEX_TEXT[8 * (15 - int'(nib)) +: 8];
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] null_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         3'd0: c = NULL_TEXT[47:40];
         3'd1: c = NULL_TEXT[39:32];
         3'd2: c = NULL_TEXT[31:24];
         3'd3: c = NULL_TEXT[23:16];
         3'd4: c = NULL_TEXT[15:8];
         3'd5: c = NULL_TEXT[7:0];
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/fsa_queue.sv =====
module fsa_queue
   import fsa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output logic      rd_valid,
   output entry_type rd_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hw/rtl/fsa_front.sv =====
module fsa_front
   import fsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [OP_W-1:0]   operation,
   input  logic [CHAR_W-1:0] char_in,
   input  logic [ARG_W-1:0]  arg_value,
   input  logic              arg_null,
   input  logic              q_full,
   output logic              q_wr,
   output entry_type         q_data
);

   logic pending_ff, pending_in;
   logic accept;

   assign full = q_full;
   assign accept = push && !q_full;

   // classify one word into a back-end command, or nothing
   always_comb begin
      pending_in = pending_ff;
      q_wr = 1'b0;
      q_data.cmd = CMD_CHAR;
      q_data.ch = char_in;
      q_data.arg = arg_value;
      if (accept) begin
         case (op_type'(operation))
            OP_FINISH: begin
               q_wr = 1'b1;
               q_data.cmd = CMD_FINISH;
               pending_in = 1'b0;
            end
            OP_STRING: begin
               q_wr = 1'b1;
            end
            OP_FORMAT: begin
               if (!pending_ff) begin
                  if (char_in == CH_PERCENT) begin
                     pending_in = 1'b1;
                  end else begin
                     q_wr = 1'b1;
                  end
               end else begin
                  pending_in = 1'b0;
                  case (char_in)
                     CH_LC_C: begin
                        q_wr = 1'b1;
                        q_data.ch = arg_value[CHAR_W-1:0];
                     end
                     CH_LC_S: begin
                        q_wr = arg_null;
                        q_data.cmd = CMD_NULL;
                     end
                     CH_LC_D, CH_LC_I: begin
                        q_wr = 1'b1;
                        q_data.cmd = CMD_DEC;
                     end
                     CH_LC_X: begin
                        q_wr = 1'b1;
                        q_data.cmd = CMD_HEX;
                     end
                     CH_LC_P: begin
                        q_wr = 1'b1;
                        q_data.cmd = CMD_PTR;
                     end
                     CH_PERCENT: begin
                        q_wr = 1'b1;
                     end
                     default: begin
                        q_wr = 1'b0;
                     end
                  endcase
               end
            end
            default: begin
               q_wr = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== hw/rtl/fsa_back.sv =====
module fsa_back
   import fsa_pkg::*;
#(
   parameter int INT_BITS = INT_BITS_DEF,
   parameter int POINTER_BITS = POINTER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  entry_type          q_data,
   output logic               q_rd,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_char_valid,
   output logic               rsp_run_last,
   output logic [COUNT_W-1:0] rsp_total_count
);

   localparam int HEX_NIBS = (INT_BITS + 3) / 4;
   localparam int PTR_NIBS = (POINTER_BITS + 3) / 4;
   localparam int HEX_SHIFT = ARG_W - 4 * HEX_NIBS;
   localparam int PTR_SHIFT = ARG_W - 4 * PTR_NIBS;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic skip_ff, skip_in;
   logic [ARG_W-1:0] conv_ff, conv_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff;
   logic char_valid_ff, run_last_ff;
   logic [COUNT_W-1:0] total_ff;

   logic out_free;
   logic emit, emit_last, emit_fin;
   logic [CHAR_W-1:0] emit_char;
   logic [COUNT_W-1:0] count_inc;
   logic [BCD_W-1:0] bcd_adj;
   logic [INT_BITS-1:0] int_v, int_mag;
   logic [3:0] dec_top, hex_top;

   assign out_free = !out_valid_ff || rsp_pop;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign int_v = q_data.arg[INT_BITS-1:0];
   assign int_mag = int_v[INT_BITS-1] ? (~int_v + {{(INT_BITS-1){1'b0}}, 1'b1}) : int_v;
   assign dec_top = bcd_ff[BCD_W-1 -: 4];
   assign hex_top = conv_ff[ARG_W-1 -: 4];

   // add-3 correction on every digit before the next shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
            bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      skip_in = skip_ff;
      conv_in = conv_ff;
      bcd_in = bcd_ff;
      q_rd = 1'b0;
      emit = 1'b0;
      emit_last = 1'b0;
      emit_fin = 1'b0;
      emit_char = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_data.cmd)
                  CMD_CHAR: begin
                     if (out_free) begin
                        q_rd = 1'b1;
                        emit = 1'b1;
                        emit_last = 1'b1;
                        emit_char = q_data.ch;
                     end
                  end
                  CMD_FINISH: begin
                     if (out_free) begin
                        q_rd = 1'b1;
                        emit = 1'b1;
                        emit_last = 1'b1;
                        emit_fin = 1'b1;
                     end
                  end
                  CMD_NULL: begin
                     q_rd = 1'b1;
                     cnt_in = '0;
                     state_in = ST_NULL;
                  end
                  CMD_DEC: begin
                     q_rd = 1'b1;
                     conv_in = ARG_W'(int_mag);
                     bcd_in = '0;
                     cnt_in = CNT_W'(INT_BITS);
                     state_in = int_v[INT_BITS-1] ? ST_SIGN : ST_DABBLE;
                  end
                  CMD_HEX: begin
                     q_rd = 1'b1;
                     conv_in = ARG_W'(q_data.arg[INT_BITS-1:0]) << HEX_SHIFT;
                     cnt_in = CNT_W'(HEX_NIBS);
                     skip_in = 1'b1;
                     state_in = ST_HEX;
                  end
                  CMD_PTR: begin
                     q_rd = 1'b1;
                     conv_in = ARG_W'(q_data.arg[POINTER_BITS-1:0]) << PTR_SHIFT;
                     cnt_in = '0;
                     state_in = ST_PFX;
                  end
                  default: begin
                     q_rd = 1'b1;
                  end
               endcase
            end
         end
         ST_NULL: begin
            if (out_free) begin
               emit = 1'b1;
               emit_char = null_char(cnt_ff[2:0]);
               emit_last = (cnt_ff == CNT_W'(NULL_LEN - 1));
               cnt_in = cnt_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               emit = 1'b1;
               emit_char = CH_MINUS;
               state_in = ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            bcd_in = {bcd_adj[BCD_W-2:0], conv_ff[INT_BITS-1]};
            conv_in = {conv_ff[ARG_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in = CNT_W'(DEC_DIGITS);
               skip_in = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (skip_ff && dec_top == 4'd0 && cnt_ff != CNT_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end else if (out_free) begin
               emit = 1'b1;
               emit_char = CH_ZERO + {4'd0, dec_top};
               emit_last = (cnt_ff == CNT_W'(1));
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
               skip_in = 1'b0;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PFX: begin
            if (out_free) begin
               emit = 1'b1;
               if (cnt_ff == '0) begin
                  emit_char = CH_ZERO;
                  cnt_in = CNT_W'(1);
               end else begin
                  emit_char = CH_LC_X;
                  cnt_in = CNT_W'(PTR_NIBS);
                  skip_in = 1'b1;
                  state_in = ST_HEX;
               end
            end
         end
         ST_HEX: begin
            if (skip_ff && hex_top == 4'd0 && cnt_ff != CNT_W'(1)) begin
               conv_in = {conv_ff[ARG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end else if (out_free) begin
               emit = 1'b1;
               emit_char = hex_char(hex_top);
               emit_last = (cnt_ff == CNT_W'(1));
               conv_in = {conv_ff[ARG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
               skip_in = 1'b0;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         count_in = emit_fin ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         skip_ff <= 1'b0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         skip_ff <= skip_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
      bcd_ff <= bcd_in;
      if (emit) begin
         out_char_ff <= emit_fin ? '0 : emit_char;
         char_valid_ff <= !emit_fin;
         run_last_ff <= emit_last;
         total_ff <= emit_fin ? count_ff : count_inc;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_total_count = total_ff;

endmodule

// ===== hw/rtl/format_string_to_ascii_core.sv =====
// a copied byte is written into the queue, then into the result register, and so reaches the rsp ports;
// a conversion then yields one byte per cycle while rsp is drained
// d and i: the word is dequeued, a minus sign is sent if negative, then INT_BITS shift-add-3 steps run
// before the first digit; each leading zero digit is skipped without a byte
// x and p: each leading zero nibble is skipped without a byte; a 4-entry queue lets req run ahead
// reset: synchronous, active high; empties the queue and result register, clears count
module format_string_to_ascii_core
   import fsa_pkg::*;
#(
   parameter int INT_BITS = INT_BITS_DEF,
   parameter int POINTER_BITS = POINTER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [CHAR_W-1:0]  req_char_in,
   input  logic [ARG_W-1:0]   req_arg_value,
   input  logic               req_arg_null,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_char_valid,
   output logic               rsp_run_last,
   output logic [COUNT_W-1:0] rsp_total_count
);

   logic q_full, q_wr, q_rd, q_valid;
   entry_type q_wr_data, q_rd_data;

   fsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .operation (req_operation),
      .char_in   (req_char_in),
      .arg_value (req_arg_value),
      .arg_null  (req_arg_null),
      .q_full    (q_full),
      .q_wr      (q_wr),
      .q_data    (q_wr_data)
   );

   fsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_en    (q_rd),
      .rd_valid (q_valid),
      .rd_data  (q_rd_data)
   );

   fsa_back #(
      .INT_BITS     (INT_BITS),
      .POINTER_BITS (POINTER_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_rd_data),
      .q_rd            (q_rd),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_total_count (rsp_total_count)
   );

`ifndef SYNTH
   a_finish_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_char_valid) |-> (rsp_run_last && rsp_out_char == '0))
      else $error("finish word malformed");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_char_valid) |-> (rsp_total_count != '0))
      else $error("byte word with zero count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");
`endif

endmodule

// ===== tb/tb_format_string_to_ascii_core.sv =====
import fsa_pkg::*;

typedef struct packed {
   logic [CHAR_W-1:0]  out_char;
   logic               char_valid;
   logic               run_last;
   logic [COUNT_W-1:0] total_count;
} ascii_word;

class ascii_scoreboard;
   ascii_word         expected_q[$];
   logic [CHAR_W-1:0] staged[$];
   logic              pct_seen;
   logic [COUNT_W-1:0] byte_count;
   string             hex_set = "0123456789abcdef";
   string             null_set = "(null)";
   int                mismatches;
   int                words_in;
   int                words_out;

   function new();
      pct_seen = 1'b0;
      byte_count = '0;
      mismatches = 0;
      words_in = 0;
      words_out = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void stage_byte(logic [CHAR_W-1:0] b);
      staged.push_back(b);
   endfunction

   function void stage_hex(logic [ARG_W-1:0] v);
      int digits;
      logic [3:0] nib;
      digits = 1;
      while (digits < 16 && (v >> (4 * digits)) != 0) digits++;
      for (int i = digits - 1; i >= 0; i--) begin
         nib = v[4 * i +: 4];
         stage_byte(hex_set[nib]);
      end
   endfunction

   function void stage_decimal(logic [ARG_W-1:0] raw);
      logic [INT_BITS_DEF-1:0] v;
      logic [INT_BITS_DEF:0]   mag;
      logic [CHAR_W-1:0]       digs[$];
      v = raw[INT_BITS_DEF-1:0];
      // two's complement magnitude, one bit wider so the most negative value fits
      mag = v[INT_BITS_DEF-1] ? ({1'b1, {INT_BITS_DEF{1'b0}}} - {1'b0, v}) : {1'b0, v};
      if (v[INT_BITS_DEF-1]) stage_byte(CH_MINUS);
      do begin
         digs.push_front(CH_ZERO + CHAR_W'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      foreach (digs[k]) stage_byte(digs[k]);
   endfunction

   function void note_input(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [ARG_W-1:0] arg, logic nul);
      op_type kind;
      logic [ARG_W-1:0] ptr;
      kind = op_type'(op);
      words_in++;
      staged.delete();
      case (kind)
         OP_FINISH: begin
            expected_q.push_back('{out_char: '0, char_valid: 1'b0, run_last: 1'b1,
                                   total_count: byte_count});
            byte_count = '0;
            pct_seen = 1'b0;
         end
         OP_STRING: stage_byte(ch);
         OP_FORMAT: begin
            if (!pct_seen) begin
               if (ch == CH_PERCENT) pct_seen = 1'b1;
               else stage_byte(ch);
            end else begin
               pct_seen = 1'b0;
               case (ch)
                  CH_LC_C: stage_byte(arg[CHAR_W-1:0]);
                  CH_LC_S: begin
                     if (nul) for (int i = 0; i < NULL_LEN; i++) stage_byte(null_set[i]);
                  end
                  CH_LC_D, CH_LC_I: stage_decimal(arg);
                  CH_LC_X: stage_hex(ARG_W'(arg[INT_BITS_DEF-1:0]));
                  CH_LC_P: begin
                     ptr = arg & ({ARG_W{1'b1}} >> (ARG_W - POINTER_BITS_DEF));
                     stage_byte(CH_ZERO);
                     stage_byte(CH_LC_X);
                     if (ptr == 0) stage_byte(CH_ZERO);
                     else stage_hex(ptr);
                  end
                  CH_PERCENT: stage_byte(CH_PERCENT);
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      foreach (staged[i]) begin
         if (byte_count != COUNT_MAX) byte_count++;
         expected_q.push_back('{out_char: staged[i], char_valid: 1'b1,
                                run_last: (i == staged.size() - 1),
                                total_count: byte_count});
      end
   endfunction

   function void check_result(logic [CHAR_W-1:0] ch, logic valid, logic last,
                              logic [COUNT_W-1:0] cnt);
      ascii_word want;
      words_out++;
      if (expected_q.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected word char=%h valid=%b last=%b count=%0d",
                  $time, ch, valid, last, cnt);
         return;
      end
      want = expected_q.pop_front();
      if (ch !== want.out_char || valid !== want.char_valid ||
          last !== want.run_last || cnt !== want.total_count) begin
         mismatches++;
         $display("%0t: mismatch expected char=%h valid=%b last=%b count=%0d",
                  $time, want.out_char, want.char_valid, want.run_last, want.total_count);
         $display("%0t:          actual   char=%h valid=%b last=%b count=%0d",
                  $time, ch, valid, last, cnt);
      end
   endfunction
endclass

module tb_format_string_to_ascii_core;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [OP_W-1:0]    req_operation = '0;
   logic [CHAR_W-1:0]  req_char_in = '0;
   logic [ARG_W-1:0]   req_arg_value = '0;
   logic               req_arg_null = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [CHAR_W-1:0]  rsp_out_char;
   logic               rsp_char_valid;
   logic               rsp_run_last;
   logic [COUNT_W-1:0] rsp_total_count;

   int   send_idle = 0;
   int   recv_idle = 0;
   bit   long_hold = 1'b0;
   int   cycle_count = 0;

   ascii_scoreboard sb = new();

   format_string_to_ascii_core #(
      .INT_BITS(INT_BITS_DEF),
      .POINTER_BITS(POINTER_BITS_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_char_in(req_char_in),
      .req_arg_value(req_arg_value),
      .req_arg_null(req_arg_null),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_char(rsp_out_char),
      .rsp_char_valid(rsp_char_valid),
      .rsp_run_last(rsp_run_last),
      .rsp_total_count(rsp_total_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // both handshakes are sampled with the values that held at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.note_input(req_operation, req_char_in, req_arg_value, req_arg_null);
         if (rsp_pop && !rsp_empty)
            sb.check_result(rsp_out_char, rsp_char_valid, rsp_run_last, rsp_total_count);
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic send_item(op_type op, logic [CHAR_W-1:0] ch, logic [ARG_W-1:0] arg,
                            logic nul);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_char_in <= ch;
      req_arg_value <= arg;
      req_arg_null <= nul;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic convert(logic [CHAR_W-1:0] ch, logic [ARG_W-1:0] arg, logic nul);
      send_item(OP_FORMAT, CH_PERCENT, {$urandom, $urandom}, 1'($urandom));
      send_item(OP_FORMAT, ch, arg, nul);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic run_directed();
      send_item(OP_FORMAT, "A", '0, 1'b0);
      send_item(OP_FORMAT, 8'h00, '1, 1'b1);
      send_item(OP_FORMAT, 8'hff, '0, 1'b0);
      convert(CH_LC_C, 64'h0123_4567_89ab_cdff, 1'b0);
      convert(CH_LC_S, '0, 1'b1);
      convert(CH_LC_S, '1, 1'b0);
      send_item(OP_STRING, 8'h00, '0, 1'b0);
      send_item(OP_STRING, 8'hff, '1, 1'b1);
      // most negative int, with junk above the low word
      convert(CH_LC_D, 64'hdead_beef_8000_0000, 1'b0);
      convert(CH_LC_I, 64'h1234_5678_7fff_ffff, 1'b0);
      convert(CH_LC_X, 64'hffff_ffff_0000_0000, 1'b0);
      convert(CH_LC_P, '1, 1'b0);
      convert(CH_LC_P, '0, 1'b0);
      convert(CH_PERCENT, '0, 1'b0);
      convert("q", '1, 1'b1);
      // string word while a percent waits, then the conversion still applies
      send_item(OP_FORMAT, CH_PERCENT, '0, 1'b0);
      send_item(OP_STRING, "z", '0, 1'b0);
      send_item(OP_FORMAT, CH_LC_X, 64'h0000_0000_ffff_ffff, 1'b0);
      send_item(OP_NONE, "B", '1, 1'b1);
      send_item(OP_FINISH, '0, '0, 1'b0);
   endtask

   task automatic random_sequence();
      int pick;
      logic [CHAR_W-1:0] conv_ch;
      logic [CHAR_W-1:0] odd_ch;
      logic [ARG_W-1:0]  arg;
      logic nul;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_item(OP_FORMAT, CHAR_W'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (pick < 80) begin
         case ($urandom_range(6))
            0: conv_ch = CH_LC_C;
            1: conv_ch = CH_LC_S;
            2: conv_ch = CH_LC_D;
            3: conv_ch = CH_LC_I;
            4: conv_ch = CH_LC_X;
            5: conv_ch = CH_LC_P;
            default: conv_ch = CH_PERCENT;
         endcase
         case ($urandom_range(5))
            0: arg = '0;
            1: arg = {$urandom, $urandom};
            2: arg = {$urandom, 32'($urandom_range(999))};
            3: arg = {$urandom, 32'h8000_0000};
            4: arg = {$urandom, -32'($urandom_range(999))};
            default: arg = 64'd1 << $urandom_range(63);
         endcase
         nul = ($urandom_range(3) == 0);
         convert(conv_ch, arg, nul);
         if (conv_ch == CH_LC_S && !nul)
            repeat ($urandom_range(5))
               send_item(OP_STRING, CHAR_W'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (pick < 88) begin
         send_item(op_type'($urandom_range(3)), CHAR_W'($urandom), {$urandom, $urandom},
                   1'($urandom));
      end else if (pick < 94) begin
         // broken conversion: unknown byte or a string word after the percent
         send_item(OP_FORMAT, CH_PERCENT, {$urandom, $urandom}, 1'($urandom));
         do odd_ch = CHAR_W'($urandom);
         while (odd_ch inside {CH_LC_C, CH_LC_S, CH_LC_D, CH_LC_I, CH_LC_X, CH_LC_P,
                               CH_PERCENT});
         send_item($urandom_range(1) ? OP_STRING : OP_FORMAT, odd_ch, {$urandom, $urandom},
                   1'($urandom));
      end else begin
         send_item(OP_FINISH, CHAR_W'($urandom), {$urandom, $urandom}, 1'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle = 20;
      recv_idle = 79;
      run_directed();
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 20; recv_idle = 79; end
            1: begin send_idle = 79; recv_idle = 20; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // receiver stops while words keep coming, so the input backs up
            if (phase == 2 && n == 20) long_hold = 1'b1;
            random_sequence();
         end
         wait_drained();
      end
      repeat (100) @(posedge clock);
      $display("covered %0d input words and %0d result words over three pacing phases",
               sb.words_in, sb.words_out);
      $display("with a %0d-cycle receiver hold and full drains between phases", HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== format_string_to_ascii_core.f =====
hw/rtl/fsa_pkg.sv
hw/rtl/fsa_queue.sv
hw/rtl/fsa_front.sv
hw/rtl/fsa_back.sv
hw/rtl/format_string_to_ascii_core.sv
tb/tb_format_string_to_ascii_core.sv
